// ----- sv/lrf_pkg.sv -----
// -----------------------------------------------------------------------------
// lrf_pkg: shared types and constants for the LR4 crossover filter
// Register map codes, history row layout, accumulator limits and the
// control/status bundles between the sequencer and the digit-serial MAC.
// -----------------------------------------------------------------------------
package lrf_pkg;

	// Fixed field widths
	localparam int COEF_W  = 32;
	localparam int CHAN_W  = 3;
	localparam int ACT_W   = 4;
	localparam int DIGIT_W = 4;
	localparam int APB_AW  = 5;
	localparam int APB_DW  = 32;
	localparam int REG_IW  = 3;

	// Register indexes (byte address / 4)
	localparam logic [REG_IW-1:0] REG_B0  = 3'd0;
	localparam logic [REG_IW-1:0] REG_B1  = 3'd1;
	localparam logic [REG_IW-1:0] REG_B2  = 3'd2;
	localparam logic [REG_IW-1:0] REG_A1  = 3'd3;
	localparam logic [REG_IW-1:0] REG_A2  = 3'd4;
	localparam logic [REG_IW-1:0] REG_ACT = 3'd5;

	localparam logic [COEF_W-1:0] B0_RESET  = 32'h4000_0000;
	localparam logic [ACT_W-1:0]  ACT_RESET = 4'd2;

	// Slots of one channel's history row
	localparam int HIST_SLOTS = 6;
	localparam int HIST_IN1   = 0;
	localparam int HIST_IN2   = 1;
	localparam int HIST_MID1  = 2;
	localparam int HIST_MID2  = 3;
	localparam int HIST_OUT1  = 4;
	localparam int HIST_OUT2  = 5;

	// Accumulator clamps at +-2^62
	localparam int ACC_W = 65;
	localparam logic signed [ACC_W-1:0] ACC_LIM  = 65'sh0_4000_0000_0000_0000;
	localparam logic signed [ACC_W-1:0] ACC_NLIM = -ACC_LIM;

	typedef struct packed {
		logic load;   // start a product with the presented operand
		logic neg;    // subtract this product
		logic rnd;    // round and saturate the accumulator
	} mac_ctl_t;

	typedef struct packed {
		logic ready;      // a product may start this cycle
		logic idle;       // nothing running or pending
		logic res_valid;  // rounded result just landed
	} mac_sts_t;

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		if (v > ACC_LIM) begin
			r = ACC_LIM;
		end else if (v < ACC_NLIM) begin
			r = ACC_NLIM;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ----- sv/lrf_hist.sv -----
// -----------------------------------------------------------------------------
// lrf_hist: per-channel filter history memory
// One row per channel holds both sections' input and output histories.
// Rows never written since reset read as zero through a valid bit per row.
// -----------------------------------------------------------------------------
module lrf_hist #(
	parameter int CHANNELS    = 8,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          rd_en,
	input  logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] rd_addr,
	output logic [lrf_pkg::HIST_SLOTS*SAMPLE_BITS-1:0]      rd_row,
	input  logic                                          wr_en,
	input  logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] wr_addr,
	input  logic [lrf_pkg::HIST_SLOTS*SAMPLE_BITS-1:0]      wr_row
);
	import lrf_pkg::*;

	localparam int ROW_W = HIST_SLOTS * SAMPLE_BITS;

	logic [ROW_W-1:0] mem [CHANNELS];
	logic [CHANNELS-1:0] vld_q;
	logic [ROW_W-1:0] rd_row_q;

	// Mark rows once written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// Write one row, read one row with registered data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			rd_row_q <= vld_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	assign rd_row = rd_row_q;

endmodule

// ----- sv/lrf_mac.sv -----
// -----------------------------------------------------------------------------
// lrf_mac: digit-serial multiply-accumulate with rounding
// The sample operand shifts out one 4-bit digit per cycle against the full
// coefficient; partial sums shift right so the adder stays 38 bits wide.
// Finished products are added to a clamped accumulator in the cycle after their last digit.
// -----------------------------------------------------------------------------
module lrf_mac #(
	parameter int SAMPLE_BITS    = 24,
	parameter int COEF_FRAC_BITS = 30
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lrf_pkg::mac_ctl_t                ctl,
	input  logic signed [SAMPLE_BITS-1:0]    operand,
	input  logic signed [lrf_pkg::COEF_W-1:0] coef,
	output lrf_pkg::mac_sts_t                sts,
	output logic signed [SAMPLE_BITS-1:0]    result
);
	import lrf_pkg::*;

	localparam int NDIG  = (SAMPLE_BITS + DIGIT_W - 1) / DIGIT_W;
	localparam int XS_W  = NDIG * DIGIT_W;
	localparam int PP_W  = COEF_W + DIGIT_W + 1;
	localparam int T_W   = PP_W + 1;
	localparam int R_W   = T_W - DIGIT_W;
	localparam int P_W   = R_W + XS_W;
	localparam int CNT_W = $clog2(NDIG);

	localparam logic signed [ACC_W-1:0] RND_HALF =
		{{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI =
		({{(ACC_W-1){1'b0}}, 1'b1} << (SAMPLE_BITS - 1)) - 1;
	localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;

	// Control state
	logic             run_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pend_q;
	logic             rnd_a_q;
	logic             rnd_b_q;
	logic             res_v_q;
	logic signed [ACC_W-1:0] acc_q;

	// Datapath registers
	logic signed [XS_W-1:0]   xs_q;
	logic signed [COEF_W-1:0] coef_q;
	logic                     neg_q;
	logic signed [R_W-1:0]    r_q;
	logic [XS_W-1:0]          l_q;
	logic signed [P_W-1:0]    prod_q;
	logic                     pneg_q;
	logic signed [SAMPLE_BITS-1:0] res_q;

	logic                     last;
	logic signed [DIGIT_W:0]  dig;
	logic signed [PP_W-1:0]   pp;
	logic signed [T_W-1:0]    t_sum;
	logic signed [R_W-1:0]    r_next;
	logic [XS_W-1:0]          l_next;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  shifted;
	logic signed [ACC_W-1:0]  clamped;

	// One digit step: top digit is signed, the rest unsigned
	assign last    = run_q && (cnt_q == CNT_W'(NDIG - 1));
	assign dig     = {last & xs_q[DIGIT_W-1], xs_q[DIGIT_W-1:0]};
	assign pp      = coef_q * dig;
	assign t_sum   = T_W'(r_q) + T_W'(pp);
	assign r_next  = R_W'(t_sum >>> DIGIT_W);
	assign l_next  = {t_sum[DIGIT_W-1:0], l_q[XS_W-1:DIGIT_W]};
	assign prod_ext = ACC_W'(prod_q);

	// Floor shift and saturate to the sample range
	always_comb begin
		shifted = acc_q >>> COEF_FRAC_BITS;
		if (shifted > SAT_HI) begin
			clamped = SAT_HI;
		end else if (shifted < SAT_LO) begin
			clamped = SAT_LO;
		end else begin
			clamped = shifted;
		end
	end

	// Sequence digits, accumulation and rounding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
			rnd_a_q <= 1'b0;
			rnd_b_q <= 1'b0;
			res_v_q <= 1'b0;
			acc_q   <= '0;
		end else begin
			if (ctl.load) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (last) begin
				run_q <= 1'b0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
			end
			pend_q  <= last;
			rnd_a_q <= ctl.rnd;
			rnd_b_q <= rnd_a_q;
			res_v_q <= rnd_b_q;
			if (pend_q) begin
				acc_q <= sat_acc(pneg_q ? acc_q - prod_ext : acc_q + prod_ext);
			end else if (rnd_a_q) begin
				acc_q <= sat_acc(acc_q + RND_HALF);
			end else if (rnd_b_q) begin
				acc_q <= '0;
			end
		end
	end

	// Shift operand digits and partial product
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			xs_q   <= XS_W'(operand);
			coef_q <= coef;
			neg_q  <= ctl.neg;
			r_q    <= '0;
		end else if (run_q) begin
			xs_q <= xs_q >>> DIGIT_W;
			r_q  <= r_next;
			l_q  <= l_next;
		end
		if (last) begin
			prod_q <= {r_next, l_next};
			pneg_q <= neg_q;
		end
		if (rnd_b_q) begin
			res_q <= SAMPLE_BITS'(clamped);
		end
	end

	assign sts.ready     = !run_q || last;
	assign sts.idle      = !run_q && !pend_q && !rnd_a_q && !rnd_b_q;
	assign sts.res_valid = res_v_q;
	assign result        = res_q;

endmodule

// ----- sv/linkwitz_riley_fourth_order_filter.sv -----
// -----------------------------------------------------------------------------
// linkwitz_riley_fourth_order_filter: per-channel LR4 filter
// Two cascaded direct-form-I biquads sharing one programmable coefficient set,
// with per-channel histories and saturation of each section to the sample width.
//
//  channel   | dir | tdata / data                  | tuser / control
//  ----------+-----+-------------------------------+------------------------
//  s_*       | in  | sample_in                     | chan
//  m_*       | out | sample_out                    | bad_channel
//  apb       | in  | coef_b0..coef_a2, active_chans| psel/penable/pwrite
//
// A good item runs ten products, N = ceil(SAMPLE_BITS/4) digits each, one 4-bit
// digit per cycle through the one shared MAC. A rejected channel skips the MAC,
// goes straight to the output register and touches no history.
// One item is in flight; the output register lets the next item enter while
// a result waits on m_tready. Reset clears control, registers and histories.
// -----------------------------------------------------------------------------
module linkwitz_riley_fourth_order_filter #(
	parameter int CHANNELS       = 8,
	parameter int SAMPLE_BITS    = 24,
	parameter int COEF_FRAC_BITS = 30
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// sample input
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // [SB-1:0] sample_in, rest zero
	input  logic [lrf_pkg::CHAN_W-1:0]          s_tuser,  // [2:0] chan
	// sample output
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,  // [SB-1:0] sample_out, rest zero
	output logic [0:0]                          m_tuser,  // [0] bad_channel
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [lrf_pkg::APB_AW-1:0]          paddr,
	input  logic [lrf_pkg::APB_DW-1:0]          pwdata,
	output logic [lrf_pkg::APB_DW-1:0]          prdata,
	output logic                                pready
);
	import lrf_pkg::*;

	localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ROW_W   = HIST_SLOTS * SAMPLE_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_WAIT = 3'd2;
	localparam logic [2:0] ST_RND  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	// Product order within a section
	localparam logic [2:0] TAP_X0 = 3'd0;
	localparam logic [2:0] TAP_X1 = 3'd1;
	localparam logic [2:0] TAP_X2 = 3'd2;
	localparam logic [2:0] TAP_Y1 = 3'd3;
	localparam logic [2:0] TAP_Y2 = 3'd4;

	logic signed [COEF_W-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
	logic [ACT_W-1:0]         act_q;

	logic [2:0]               state_q;
	logic                     sec_q;
	logic [2:0]               k_q;
	logic                     bad_q;
	logic [AW-1:0]            chan_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] mid_q;

	logic [SAMPLE_BITS-1:0]   out_q;
	logic                     out_bad_q;
	logic                     mvalid_q;

	logic                     in_fire;
	logic                     in_bad;
	logic                     fin_fire;
	logic                     cfg_wr;
	logic [REG_IW-1:0]        reg_idx;

	mac_ctl_t                 mac_ctl;
	mac_sts_t                 mac_sts;
	logic signed [SAMPLE_BITS-1:0] mac_op;
	logic signed [COEF_W-1:0] mac_coef;
	logic signed [SAMPLE_BITS-1:0] mac_res;

	logic [ROW_W-1:0]         rd_row;
	logic [ROW_W-1:0]         wr_row;
	logic signed [SAMPLE_BITS-1:0] h_in1, h_in2, h_mid1, h_mid2, h_out1;

	// Configuration registers
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_AW-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q  <= B0_RESET;
			b1_q  <= '0;
			b2_q  <= '0;
			a1_q  <= '0;
			a2_q  <= '0;
			act_q <= ACT_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_B0:  b0_q  <= pwdata;
				REG_B1:  b1_q  <= pwdata;
				REG_B2:  b2_q  <= pwdata;
				REG_A1:  a1_q  <= pwdata;
				REG_A2:  a2_q  <= pwdata;
				REG_ACT: act_q <= pwdata[ACT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_B0:  prdata = b0_q;
			REG_B1:  prdata = b1_q;
			REG_B2:  prdata = b2_q;
			REG_A1:  prdata = a1_q;
			REG_A2:  prdata = a2_q;
			REG_ACT: prdata = APB_DW'(act_q);
			default: prdata = '0;
		endcase
	end

	// Input beat and channel check
	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign in_bad   = ({1'b0, s_tuser} >= act_q) || (32'(s_tuser) >= CHANNELS);
	assign fin_fire = (state_q == ST_FIN) && (!mvalid_q || m_tready);

	// History row fields
	assign h_in1  = rd_row[HIST_IN1*SAMPLE_BITS +: SAMPLE_BITS];
	assign h_in2  = rd_row[HIST_IN2*SAMPLE_BITS +: SAMPLE_BITS];
	assign h_mid1 = rd_row[HIST_MID1*SAMPLE_BITS +: SAMPLE_BITS];
	assign h_mid2 = rd_row[HIST_MID2*SAMPLE_BITS +: SAMPLE_BITS];
	assign h_out1 = rd_row[HIST_OUT1*SAMPLE_BITS +: SAMPLE_BITS];

	// Shift the histories by one sample
	always_comb begin
		wr_row = '0;
		wr_row[HIST_IN1*SAMPLE_BITS +: SAMPLE_BITS]  = x_q;
		wr_row[HIST_IN2*SAMPLE_BITS +: SAMPLE_BITS]  = h_in1;
		wr_row[HIST_MID1*SAMPLE_BITS +: SAMPLE_BITS] = mid_q;
		wr_row[HIST_MID2*SAMPLE_BITS +: SAMPLE_BITS] = h_mid1;
		wr_row[HIST_OUT1*SAMPLE_BITS +: SAMPLE_BITS] = mac_res;
		wr_row[HIST_OUT2*SAMPLE_BITS +: SAMPLE_BITS] = h_out1;
	end

	// Pick operand and coefficient for the current product
	always_comb begin
		case (k_q)
			TAP_X0: begin
				mac_op   = sec_q ? mid_q : x_q;
				mac_coef = b0_q;
			end
			TAP_X1: begin
				mac_op   = sec_q ? h_mid1 : h_in1;
				mac_coef = b1_q;
			end
			TAP_X2: begin
				mac_op   = sec_q ? h_mid2 : h_in2;
				mac_coef = b2_q;
			end
			TAP_Y1: begin
				mac_op   = sec_q ? h_out1 : h_mid1;
				mac_coef = a1_q;
			end
			default: begin
				mac_op   = sec_q ? rd_row[HIST_OUT2*SAMPLE_BITS +: SAMPLE_BITS] : h_mid2;
				mac_coef = a2_q;
			end
		endcase
	end

	always_comb begin
		mac_ctl      = '0;
		mac_ctl.load = (state_q == ST_MUL) && mac_sts.ready;
		mac_ctl.neg  = (k_q >= TAP_Y1);
		mac_ctl.rnd  = (state_q == ST_WAIT) && mac_sts.idle;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sec_q   <= 1'b0;
			k_q     <= TAP_X0;
			bad_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						bad_q   <= in_bad;
						sec_q   <= 1'b0;
						k_q     <= TAP_X0;
						state_q <= in_bad ? ST_FIN : ST_MUL;
					end
				end
				ST_MUL: begin
					if (mac_sts.ready) begin
						if (k_q == TAP_Y2) begin
							state_q <= ST_WAIT;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				ST_WAIT: begin
					if (mac_sts.idle) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					if (mac_sts.res_valid) begin
						if (!sec_q) begin
							sec_q   <= 1'b1;
							k_q     <= TAP_X0;
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (fin_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold item payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q    <= s_tdata[SAMPLE_BITS-1:0];
			chan_q <= AW'(s_tuser);
		end
		if ((state_q == ST_RND) && mac_sts.res_valid && !sec_q) begin
			mid_q <= mac_res;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (fin_fire) begin
			mvalid_q <= 1'b1;
		end else if (m_tready) begin
			mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			out_q     <= bad_q ? '0 : mac_res;
			out_bad_q <= bad_q;
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = TDATA_W'(out_q);
	assign m_tuser  = out_bad_q;

	lrf_hist #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_fire && !in_bad),
		.rd_addr (AW'(s_tuser)),
		.rd_row  (rd_row),
		.wr_en   (fin_fire && !bad_q),
		.wr_addr (chan_q),
		.wr_row  (wr_row)
	);

	lrf_mac #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mac_ctl),
		.operand (mac_op),
		.coef    (mac_coef),
		.sts     (mac_sts),
		.result  (mac_res)
	);

endmodule

// ----- sv/lrf_chk.sv -----
// -----------------------------------------------------------------------------
// lrf_chk: port-level checks for the LR4 filter
// Watches the stream and configuration ports; bound to the top level.
// -----------------------------------------------------------------------------
module lrf_chk #(
	parameter int TDATA_W = 24
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [TDATA_W-1:0]         m_tdata,
	input logic [0:0]                 m_tuser,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic                       pready,
	input logic [lrf_pkg::APB_AW-1:0] paddr,
	input logic [lrf_pkg::APB_DW-1:0] pwdata,
	input logic [lrf_pkg::APB_DW-1:0] prdata
);
	import lrf_pkg::*;

	// Stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// Rejected channel gives a zero sample
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("rejected channel with nonzero sample");

	// One item at a time: no input beat right after another
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// Coefficient reads back what was written
	a_coef_rb: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr[APB_AW-1:2] <= REG_A2)
		##1 (paddr == $past(paddr)) |-> prdata == $past(pwdata))
		else $error("coefficient readback mismatch");

endmodule

bind linkwitz_riley_fourth_order_filter lrf_chk #(.TDATA_W(TDATA_W)) u_lrf_chk (.*);

// ----- tb/sv/linkwitz_riley_fourth_order_filter_tb.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// linkwitz_riley_fourth_order_filter_tb: self-checking bench for the LR4 filter
// Drives sample beats on the input stream and coefficient sets over APB. A
// fixed-point model of the two cascaded biquads, with its own per-channel
// histories, predicts every output beat. The output stream is checked field by
// field against that prediction. Random stalls on both streams vary timing.
// -----------------------------------------------------------------------------
module linkwitz_riley_fourth_order_filter_tb;

	import lrf_pkg::*;

	localparam int     CHANNELS    = 8;
	localparam int     SAMPLE_W    = 24;
	localparam int     COEF_FRAC   = 30;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};
	localparam int     CYCLE_LIMIT = 400000;
	localparam int     END_WAIT    = 100;

	// Addresses past the register map; writes there must be dropped
	localparam logic [REG_IW-1:0] REG_SPARE_LO = REG_ACT + 3'd1;
	localparam logic [REG_IW-1:0] REG_SPARE_HI = REG_ACT + 3'd2;

	// Common coefficient values, Q2.30
	localparam logic [COEF_W-1:0] COEF_ONE  = 32'h4000_0000;
	localparam logic [COEF_W-1:0] COEF_HALF = 32'h2000_0000;
	localparam logic [COEF_W-1:0] COEF_MAX  = 32'h7FFF_FFFF;
	localparam logic [COEF_W-1:0] COEF_MIN  = 32'h8000_0000;

	// Crossover sets at 1 kHz, 48 kHz sample rate, Q 0.707
	localparam logic [COEF_W-1:0] XO_A1    = -32'sd1949207556;
	localparam logic [COEF_W-1:0] XO_A2    = 32'sd892285898;
	localparam logic [COEF_W-1:0] LP_B0    = 32'sd4204773;
	localparam logic [COEF_W-1:0] LP_B1    = 32'sd8409546;
	localparam logic [COEF_W-1:0] HP_B0    = 32'sd978809088;
	localparam logic [COEF_W-1:0] HP_B1    = -32'sd1957618176;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       bad;
	} lr_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [SAMPLE_W-1:0] s_tdata  = '0;  // [23:0] sample_in
	logic [CHAN_W-1:0]   s_tuser  = '0;  // [2:0] chan
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [SAMPLE_W-1:0] m_tdata;        // [23:0] sample_out
	logic [0:0]          m_tuser;        // [0] bad_channel

	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [APB_AW-1:0] paddr   = '0;
	logic [APB_DW-1:0] pwdata  = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	// Register shadow
	logic signed [COEF_W-1:0] k_b0 = B0_RESET;
	logic signed [COEF_W-1:0] k_b1 = '0;
	logic signed [COEF_W-1:0] k_b2 = '0;
	logic signed [COEF_W-1:0] k_a1 = '0;
	logic signed [COEF_W-1:0] k_a2 = '0;
	logic [ACT_W-1:0]         k_active = ACT_RESET;

	// Per-channel filter history
	logic signed [SAMPLE_W-1:0] hist_in1  [CHANNELS] = '{default: '0};
	logic signed [SAMPLE_W-1:0] hist_in2  [CHANNELS] = '{default: '0};
	logic signed [SAMPLE_W-1:0] hist_mid1 [CHANNELS] = '{default: '0};
	logic signed [SAMPLE_W-1:0] hist_mid2 [CHANNELS] = '{default: '0};
	logic signed [SAMPLE_W-1:0] hist_out1 [CHANNELS] = '{default: '0};
	logic signed [SAMPLE_W-1:0] hist_out2 [CHANNELS] = '{default: '0};

	lr_result_t expected_results[$];
	lr_result_t checker_want;
	int         mismatch_count = 0;
	bit         idle_on = 1'b1;
	int         sink_hold = 0;

	linkwitz_riley_fourth_order_filter #(
		.CHANNELS       (CHANNELS),
		.SAMPLE_BITS    (SAMPLE_W),
		.COEF_FRAC_BITS (COEF_FRAC)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #1 clk = ~clk;

	// One direct-form-I section with the current coefficient set
	function automatic logic signed [SAMPLE_W-1:0] biquad_section(
		input logic signed [SAMPLE_W-1:0] x,
		input logic signed [SAMPLE_W-1:0] x1,
		input logic signed [SAMPLE_W-1:0] x2,
		input logic signed [SAMPLE_W-1:0] y1,
		input logic signed [SAMPLE_W-1:0] y2
	);
		longint acc;
		longint q;
		// partial sums stay far inside the +-2^62 clamp at these widths
		acc = longint'(k_b0) * longint'(x) + longint'(k_b1) * longint'(x1)
			+ longint'(k_b2) * longint'(x2) - longint'(k_a1) * longint'(y1)
			- longint'(k_a2) * longint'(y2);
		// round half up, then saturate to the sample width
		q = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
		if (q > SAMPLE_MAX) begin
			q = SAMPLE_MAX;
		end else if (q < SAMPLE_MIN) begin
			q = SAMPLE_MIN;
		end
		return q[SAMPLE_W-1:0];
	endfunction

	// Run one sample through both sections and advance the channel history
	function automatic lr_result_t lr4_predict(
		input logic signed [SAMPLE_W-1:0] x,
		input logic [CHAN_W-1:0]          ch
	);
		lr_result_t                 r;
		logic signed [SAMPLE_W-1:0] mid;
		logic signed [SAMPLE_W-1:0] y;
		if ({1'b0, ch} >= k_active) begin
			r.sample = '0;
			r.bad    = 1'b1;
			return r;
		end
		mid = biquad_section(x, hist_in1[ch], hist_in2[ch], hist_mid1[ch], hist_mid2[ch]);
		y   = biquad_section(mid, hist_mid1[ch], hist_mid2[ch], hist_out1[ch], hist_out2[ch]);
		hist_in2[ch]  = hist_in1[ch];
		hist_in1[ch]  = x;
		hist_mid2[ch] = hist_mid1[ch];
		hist_mid1[ch] = mid;
		hist_out2[ch] = hist_out1[ch];
		hist_out1[ch] = y;
		r.sample = y;
		r.bad    = 1'b0;
		return r;
	endfunction

	function automatic logic [APB_DW-1:0] shadow_value(input logic [REG_IW-1:0] idx);
		case (idx)
			REG_B0:  return k_b0;
			REG_B1:  return k_b1;
			REG_B2:  return k_b2;
			REG_A1:  return k_a1;
			REG_A2:  return k_a2;
			REG_ACT: return {{(APB_DW-ACT_W){1'b0}}, k_active};
			default: return '0;
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0:       return SAMPLE_MAX;
			1:       return SAMPLE_MIN;
			2:       return SAMPLE_W'($urandom_range(0, 2000) - 1000);
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	task automatic report_mismatch(input string what, input longint want_v, input longint got_v);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want_v, got_v);
		end
	endtask

	// APB write: setup and access phases, then idle
	task automatic write_reg(input logic [REG_IW-1:0] idx, input logic [APB_DW-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_B0:  k_b0 = val;
			REG_B1:  k_b1 = val;
			REG_B2:  k_b2 = val;
			REG_A1:  k_a1 = val;
			REG_A2:  k_a2 = val;
			REG_ACT: k_active = val[ACT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// APB read, compared against the shadow
	task automatic check_reg(input logic [REG_IW-1:0] idx);
		logic [APB_DW-1:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== shadow_value(idx)) begin
			report_mismatch($sformatf("prdata reg %0d", idx), shadow_value(idx), got);
		end
		@(posedge clk);
	endtask

	task automatic load_coefs(
		input logic [COEF_W-1:0] b0,
		input logic [COEF_W-1:0] b1,
		input logic [COEF_W-1:0] b2,
		input logic [COEF_W-1:0] a1,
		input logic [COEF_W-1:0] a2,
		input logic [APB_DW-1:0] act
	);
		write_reg(REG_B0, b0);
		write_reg(REG_B1, b1);
		write_reg(REG_B2, b2);
		write_reg(REG_A1, a1);
		write_reg(REG_A2, a2);
		write_reg(REG_ACT, act);
	endtask

	// Send one sample beat; predict its result once accepted
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic [CHAN_W-1:0] ch);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= x;
		s_tuser  <= ch;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_results.push_back(lr4_predict(x, ch));
	endtask

	// Hold the input until every predicted result has come out
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic stream_items(input int count);
		repeat (count) send_sample(pick_sample(), CHAN_W'($urandom_range(0, CHANNELS - 1)));
	endtask

	// Sink side: accept beats with random stall bursts
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold = sink_hold - 1;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 11) == 0) begin
			sink_hold = $urandom_range(0, 16);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare each output beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected output beat", 0, $signed(m_tdata));
			end else begin
				checker_want = expected_results.pop_front();
				if (m_tdata !== checker_want.sample) begin
					report_mismatch("sample_out", checker_want.sample, $signed(m_tdata));
				end
				if (m_tuser[0] !== checker_want.bad) begin
					report_mismatch("bad_channel", checker_want.bad, m_tuser[0]);
				end
			end
		end
	end

	// Reset values: unity gain on two channels, the rest rejected
	task automatic test_reset_values();
		for (int i = REG_B0; i <= REG_ACT; i++) check_reg(REG_IW'(i));
		send_sample(SAMPLE_MAX, 3'd0);
		send_sample(SAMPLE_MIN, 3'd0);
		send_sample(-1, 3'd1);
		send_sample(0, 3'd1);
		send_sample(SAMPLE_MAX, 3'd2);
		send_sample(SAMPLE_MIN, 3'd7);
		drain_results();
	endtask

	// Register map: read back, width truncation, spare addresses dropped
	task automatic test_register_map();
		load_coefs(COEF_MAX, COEF_MIN, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'h0000_0001,
			32'hFFFF_FFF3);
		for (int i = REG_B0; i <= REG_ACT; i++) check_reg(REG_IW'(i));
		write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_HI, 32'h1234_5678);
		for (int i = REG_B0; i <= REG_ACT; i++) check_reg(REG_IW'(i));
	endtask

	// Saturation at both rails, feedback growth, and round half up
	task automatic test_saturation_rounding();
		drain_results();
		load_coefs(COEF_MAX, '0, '0, '0, '0, CHANNELS);
		send_sample(SAMPLE_MAX, 3'd0);
		send_sample(SAMPLE_MIN, 3'd1);
		drain_results();
		write_reg(REG_B0, COEF_MIN);
		send_sample(SAMPLE_MIN, 3'd2);
		send_sample(SAMPLE_MAX, 3'd2);
		drain_results();
		load_coefs(COEF_ONE, '0, '0, COEF_MIN, '0, CHANNELS);
		send_sample(SAMPLE_MAX, 3'd3);
		send_sample(SAMPLE_MAX, 3'd3);
		send_sample(0, 3'd3);
		drain_results();
		load_coefs(COEF_HALF, '0, '0, '0, '0, CHANNELS);
		send_sample(1, 3'd4);
		send_sample(-1, 3'd4);
		send_sample(3, 3'd4);
		send_sample(-3, 3'd4);
		drain_results();
	endtask

	// Active count: zero, oversized, one; rejected beats leave history alone
	task automatic test_channel_gating();
		load_coefs(COEF_ONE, COEF_HALF, '0, '0, '0, 4);
		send_sample(1000, 3'd5);
		send_sample(2000, 3'd3);
		drain_results();
		write_reg(REG_ACT, 0);
		send_sample(500, 3'd0);
		drain_results();
		write_reg(REG_ACT, 15);
		send_sample(-700, 3'd5);
		send_sample(SAMPLE_MAX, 3'd7);
		drain_results();
		write_reg(REG_ACT, 1);
		send_sample(300, 3'd1);
		send_sample(400, 3'd0);
		drain_results();
	endtask

	// Low-pass, high-pass and all-pass crossover sets with random traffic on all channels
	task automatic test_crossover_sets();
		load_coefs(LP_B0, LP_B1, LP_B0, XO_A1, XO_A2, CHANNELS);
		stream_items(100);
		drain_results();
		load_coefs(HP_B0, HP_B1, HP_B0, XO_A1, XO_A2, 6);
		stream_items(100);
		drain_results();
		load_coefs(XO_A2, XO_A1, COEF_ONE, XO_A1, XO_A2, 7);
		stream_items(100);
		drain_results();
	endtask

	// Random coefficient sets of varied magnitude; last phase at full rate
	task automatic test_random_coefs();
		for (int phase = 0; phase < 2; phase++) begin
			load_coefs($signed($urandom()) >>> $urandom_range(0, 6),
				$signed($urandom()) >>> $urandom_range(0, 6),
				$signed($urandom()) >>> $urandom_range(0, 6),
				$signed($urandom()) >>> $urandom_range(0, 6),
				$signed($urandom()) >>> $urandom_range(0, 6),
				$urandom_range(1, 15));
			if (phase == 1) begin
				idle_on = 1'b0;
			end
			stream_items(100);
			drain_results();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_register_map();
		test_saturation_rounding();
		test_channel_gating();
		test_crossover_sets();
		test_random_coefs();
		repeat (END_WAIT) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("linkwitz_riley_fourth_order_filter_tb: PASS");
		end else begin
			$display("linkwitz_riley_fourth_order_filter_tb: FAIL");
		end
		$finish;
	end

	// Watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("linkwitz_riley_fourth_order_filter_tb: FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
sv/lrf_pkg.sv
sv/lrf_hist.sv
sv/lrf_mac.sv
sv/linkwitz_riley_fourth_order_filter.sv
sv/lrf_chk.sv
tb/sv/linkwitz_riley_fourth_order_filter_tb.sv
